// ===== design/tcri_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcri_pkg;

	// timecode field widths
	localparam int unsigned HoursW   = 5;
	localparam int unsigned MinutesW = 6;
	localparam int unsigned SecondsW = 6;
	localparam int unsigned FramesW  = 5;

	// run word widths
	localparam int unsigned PosW    = 22;
	localparam int unsigned LenW    = 32;
	localparam int unsigned RunNumW = 32;
	localparam int unsigned ActionW = 2;

	// 25 fps timecode arithmetic
	localparam int unsigned Fps         = 25;
	localparam int unsigned Sixty       = 60;
	localparam int unsigned SecFrames   = Fps;
	localparam int unsigned MinFrames   = Sixty * SecFrames;
	localparam int unsigned HourFrames  = Sixty * MinFrames;

	// action codes
	localparam logic [ActionW-1:0] ActNew    = 2'd0;
	localparam logic [ActionW-1:0] ActInc    = 2'd1;
	localparam logic [ActionW-1:0] ActFrozen = 2'd2;

	// one reported run
	typedef struct packed {
		logic [ActionW-1:0] action;
		logic [RunNumW-1:0] run_number;
		logic [PosW-1:0]    run_start;
		logic [LenW-1:0]    run_length;
		logic               run_frozen;
		logic               saturated;
	} run_word_t;

endpackage

`default_nettype wire

// ===== design/tcri_pos.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcri_pos (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            tc_valid,
	output logic                                 tc_stall,
	input  wire logic [tcri_pkg::HoursW-1:0]     hours,
	input  wire logic [tcri_pkg::MinutesW-1:0]   minutes,
	input  wire logic [tcri_pkg::SecondsW-1:0]   seconds,
	input  wire logic [tcri_pkg::FramesW-1:0]    frames,
	output logic                                 pos_valid,
	input  wire logic                            pos_stall,
	output logic [tcri_pkg::PosW-1:0]            pos
);

	logic                            valid_s1;
	logic [tcri_pkg::HoursW-1:0]     hours_s1;
	logic [tcri_pkg::MinutesW-1:0]   minutes_s1;
	logic [tcri_pkg::SecondsW-1:0]   seconds_s1;
	logic [tcri_pkg::FramesW-1:0]    frames_s1;
	logic                            valid_s2;
	logic [tcri_pkg::PosW-1:0]       pos_s2;
	logic                            adv_s2;
	logic                            take_s1;
	logic [tcri_pkg::PosW-1:0]       count;

	// stage handshake, bubbles collapse
	assign adv_s2   = valid_s1 && (!valid_s2 || !pos_stall);
	assign tc_stall = valid_s1 && !adv_s2;
	assign take_s1  = tc_valid && !tc_stall;

	// frame count from timecode fields
	assign count = tcri_pkg::PosW'(hours_s1)   * tcri_pkg::PosW'(tcri_pkg::HourFrames)
	             + tcri_pkg::PosW'(minutes_s1) * tcri_pkg::PosW'(tcri_pkg::MinFrames)
	             + tcri_pkg::PosW'(seconds_s1) * tcri_pkg::PosW'(tcri_pkg::SecFrames)
	             + tcri_pkg::PosW'(frames_s1);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_s1 || adv_s2) begin
				valid_s1 <= take_s1;
			end
			if (adv_s2 || !pos_stall) begin
				valid_s2 <= adv_s2;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take_s1) begin
			hours_s1   <= hours;
			minutes_s1 <= minutes;
			seconds_s1 <= seconds;
			frames_s1  <= frames;
		end
		if (adv_s2) begin
			pos_s2 <= count;
		end
	end

	assign pos_valid = valid_s2;
	assign pos       = pos_s2;

endmodule

`default_nettype wire

// ===== design/tcri_run.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcri_run (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        pos_valid,
	output logic                             pos_stall,
	input  wire logic [tcri_pkg::PosW-1:0]   pos,
	output logic                             run_valid,
	input  wire logic                        run_stall,
	output tcri_pkg::run_word_t              word
);

	localparam logic [tcri_pkg::LenW-1:0]    LenMax = '1;
	localparam logic [tcri_pkg::RunNumW-1:0] NumMax = '1;

	logic                            have_run_q;
	logic [tcri_pkg::PosW-1:0]       start_q;
	logic [tcri_pkg::LenW-1:0]       length_q;
	logic                            frozen_q;
	logic [tcri_pkg::RunNumW-1:0]    counter_q;
	logic                            out_valid_q;
	tcri_pkg::run_word_t             out_q;

	logic                            take;
	logic                            hit_inc;
	logic                            hit_frozen;
	logic [tcri_pkg::LenW-1:0]       len_grown;
	logic [tcri_pkg::RunNumW-1:0]    num_next;
	tcri_pkg::run_word_t             nxt;

	assign pos_stall = out_valid_q && run_stall;
	assign take      = pos_valid && !pos_stall;

	// run match tests
	assign hit_inc    = have_run_q
	                  && (({1'b0, tcri_pkg::LenW'(start_q)} + {1'b0, length_q})
	                      == {1'b0, tcri_pkg::LenW'(pos)});
	assign hit_frozen = have_run_q && (start_q == pos)
	                  && (frozen_q || (length_q == tcri_pkg::LenW'(1)));
	assign len_grown  = (length_q == LenMax) ? LenMax : length_q + 1'b1;

	// run number for a new run
	always_comb begin
		if (!have_run_q) begin
			num_next = '0;
		end else if (counter_q == NumMax) begin
			num_next = NumMax;
		end else begin
			num_next = counter_q + 1'b1;
		end
	end

	// next run word
	always_comb begin
		if (hit_inc) begin
			nxt.action     = tcri_pkg::ActInc;
			nxt.run_number = counter_q;
			nxt.run_start  = start_q;
			nxt.run_length = len_grown;
			nxt.run_frozen = frozen_q;
		end else if (hit_frozen) begin
			nxt.action     = tcri_pkg::ActFrozen;
			nxt.run_number = counter_q;
			nxt.run_start  = start_q;
			nxt.run_length = len_grown;
			nxt.run_frozen = 1'b1;
		end else begin
			nxt.action     = tcri_pkg::ActNew;
			nxt.run_number = num_next;
			nxt.run_start  = pos;
			nxt.run_length = tcri_pkg::LenW'(1);
			nxt.run_frozen = 1'b0;
		end
		nxt.saturated = (nxt.run_length == LenMax) || (nxt.run_number == NumMax);
	end

	// run state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_run_q  <= 1'b0;
			start_q     <= '0;
			length_q    <= '0;
			frozen_q    <= 1'b0;
			counter_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				have_run_q <= 1'b1;
				start_q    <= nxt.run_start;
				length_q   <= nxt.run_length;
				frozen_q   <= nxt.run_frozen;
				counter_q  <= nxt.run_number;
			end
			if (take || !run_stall) begin
				out_valid_q <= take;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= nxt;
		end
	end

	assign run_valid = out_valid_q;
	assign word      = out_q;

endmodule

`default_nettype wire

// ===== design/timecode_run_index_builder_top.sv =====
// a word taken on tc passes the input, frame count and result registers, then goes out on run
// throughput: one word per cycle unless stalled; the run state loop closes in the result stage
// the input and frame count stages collapse bubbles, so a word is taken while a result waits
// reset: arst_n clears all valid bits and the run state, so the first word starts run 0
`timescale 1ns / 1ps
`default_nettype none

module timecode_run_index_builder_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            tc_valid,
	output logic                                 tc_stall,
	input  wire logic [tcri_pkg::HoursW-1:0]     hours,
	input  wire logic [tcri_pkg::MinutesW-1:0]   minutes,
	input  wire logic [tcri_pkg::SecondsW-1:0]   seconds,
	input  wire logic [tcri_pkg::FramesW-1:0]    frames,
	output logic                                 run_valid,
	input  wire logic                            run_stall,
	output logic [tcri_pkg::ActionW-1:0]         action,
	output logic [tcri_pkg::RunNumW-1:0]         run_number,
	output logic [tcri_pkg::PosW-1:0]            run_start,
	output logic [tcri_pkg::LenW-1:0]            run_length,
	output logic                                 run_frozen,
	output logic                                 saturated
);

	logic                        pos_valid;
	logic                        pos_stall;
	logic [tcri_pkg::PosW-1:0]   pos;
	tcri_pkg::run_word_t         word;

	// timecode to frame count
	tcri_pos u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.tc_valid  (tc_valid),
		.tc_stall  (tc_stall),
		.hours     (hours),
		.minutes   (minutes),
		.seconds   (seconds),
		.frames    (frames),
		.pos_valid (pos_valid),
		.pos_stall (pos_stall),
		.pos       (pos)
	);

	// run tracking and result register
	tcri_run u_run (
		.clk       (clk),
		.arst_n    (arst_n),
		.pos_valid (pos_valid),
		.pos_stall (pos_stall),
		.pos       (pos),
		.run_valid (run_valid),
		.run_stall (run_stall),
		.word      (word)
	);

	assign action     = word.action;
	assign run_number = word.run_number;
	assign run_start  = word.run_start;
	assign run_length = word.run_length;
	assign run_frozen = word.run_frozen;
	assign saturated  = word.saturated;

endmodule

`default_nettype wire

// ===== tb/timecode_run_index_builder_top_test.sv =====
`timescale 1ns / 1ps
`default_nettype none

module timecode_run_index_builder_top_test;
	import tcri_pkg::*;

	// one timecode word as queued for the driver, with its lead-in gap
	typedef struct {
		logic [HoursW-1:0]   hh;
		logic [MinutesW-1:0] mm;
		logic [SecondsW-1:0] ss;
		logic [FramesW-1:0]  ff;
		int unsigned         gap;
		bit                  drain;
	} timecode_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                tc_valid = 1'b0;
	logic                tc_stall;
	logic [HoursW-1:0]   hours = '0;
	logic [MinutesW-1:0] minutes = '0;
	logic [SecondsW-1:0] seconds = '0;
	logic [FramesW-1:0]  frames = '0;
	logic                run_valid;
	logic                run_stall = 1'b0;
	logic [ActionW-1:0]  action;
	logic [RunNumW-1:0]  run_number;
	logic [PosW-1:0]     run_start;
	logic [LenW-1:0]     run_length;
	logic                run_frozen;
	logic                saturated;

	timecode_run_index_builder_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.tc_valid   (tc_valid),
		.tc_stall   (tc_stall),
		.hours      (hours),
		.minutes    (minutes),
		.seconds    (seconds),
		.frames     (frames),
		.run_valid  (run_valid),
		.run_stall  (run_stall),
		.action     (action),
		.run_number (run_number),
		.run_start  (run_start),
		.run_length (run_length),
		.run_frozen (run_frozen),
		.saturated  (saturated)
	);

	timecode_t timecodes_pending[$];
	run_word_t runs_due[$];

	// tracked run state
	bit                 run_open = 1'b0;
	logic [PosW-1:0]    run_first = '0;
	logic [LenW-1:0]    run_len = '0;
	logic               run_still = 1'b0;
	logic [RunNumW-1:0] run_idx = '0;

	timecode_t   offered;
	bit          gap_armed;
	bit          send_now;
	int unsigned gap_left;
	int unsigned hold_left;
	int unsigned words_taken = 0;
	int unsigned runs_seen = 0;
	int unsigned mismatches = 0;
	int unsigned action_hits[4] = '{0, 0, 0, 0};

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run tracking: fold one timecode into the current run
	function automatic run_word_t advance_run(input timecode_t t);
		logic [31:0]     full;
		logic [PosW-1:0] pos;
		logic [LenW:0]   reach;
		run_word_t       w;
		full = 32'(t.hh) * HourFrames + 32'(t.mm) * MinFrames + 32'(t.ss) * SecFrames
			+ 32'(t.ff);
		pos = full[PosW-1:0];
		reach = {1'b0, run_len} + (LenW + 1)'(run_first);
		if (run_open && reach == (LenW + 1)'(pos)) begin
			run_len = (run_len == '1) ? run_len : run_len + 1'b1;
			w.action = ActInc;
		end else if (run_open && run_first == pos && (run_still || run_len == 1)) begin
			run_still = 1'b1;
			run_len = (run_len == '1) ? run_len : run_len + 1'b1;
			w.action = ActFrozen;
		end else begin
			if (!run_open)
				run_idx = '0;
			else if (run_idx != '1)
				run_idx = run_idx + 1'b1;
			run_open = 1'b1;
			run_first = pos;
			run_len = 1;
			run_still = 1'b0;
			w.action = ActNew;
		end
		w.run_number = run_idx;
		w.run_start = run_first;
		w.run_length = run_len;
		w.run_frozen = run_still;
		w.saturated = (run_len == '1) || (run_idx == '1);
		return w;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] want,
		input logic [63:0] got);
		if (mismatches < 40)
			$display("%0t: run word %0d, %s: expected %0h, got %0h", $realtime, runs_seen,
				what, want, got);
		mismatches++;
	endtask

	task automatic queue_tc(input int unsigned h, input int unsigned m, input int unsigned s,
		input int unsigned f, input int unsigned gap, input bit drain);
		timecode_t t;
		t.hh = h[HoursW-1:0];
		t.mm = m[MinutesW-1:0];
		t.ss = s[SecondsW-1:0];
		t.ff = f[FramesW-1:0];
		t.gap = gap;
		t.drain = drain;
		timecodes_pending.push_back(t);
	endtask

	// a frame count as timecode, sometimes with one second folded into the frame field
	task automatic queue_count(input int unsigned c, input int unsigned gap, input bit drain);
		int unsigned h, m, s, f;
		h = c / HourFrames;
		m = (c / MinFrames) % Sixty;
		s = (c / SecFrames) % Sixty;
		f = c % Fps;
		if (s > 0 && f < 7 && $urandom_range(0, 7) == 0) begin
			s--;
			f += Fps;
		end
		queue_tc(h, m, s, f, gap, drain);
	endtask

	// sender gap, none in one quiet stretch
	function automatic int unsigned pick_gap();
		if (timecodes_pending.size() >= 400 && timecodes_pending.size() < 520)
			return 0;
		return $urandom_range(0, 4);
	endfunction

	// driver: offer queued words, hold a stalled word, predict on accept
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_valid <= 1'b0;
			hours <= '0;
			minutes <= '0;
			seconds <= '0;
			frames <= '0;
			gap_armed = 1'b0;
			gap_left = 0;
		end else begin
			if (tc_valid && !tc_stall) begin
				runs_due.push_back(advance_run(offered));
				words_taken++;
			end
			if (!(tc_valid && tc_stall)) begin
				send_now = 1'b0;
				if (timecodes_pending.size() != 0) begin
					if (!gap_armed) begin
						gap_left = timecodes_pending[0].gap;
						gap_armed = 1'b1;
					end
					if (gap_left != 0)
						gap_left--;
					else if (!(timecodes_pending[0].drain && runs_due.size() != 0))
						send_now = 1'b1;
				end
				if (send_now) begin
					offered = timecodes_pending.pop_front();
					gap_armed = 1'b0;
					tc_valid <= 1'b1;
					hours <= offered.hh;
					minutes <= offered.mm;
					seconds <= offered.ss;
					frames <= offered.ff;
				end else begin
					tc_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each run word against the oldest expectation, draw stalls
	always @(posedge clk or negedge arst_n) begin
		run_word_t want;
		if (!arst_n) begin
			run_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (run_valid && !run_stall) begin
				runs_seen++;
				if (runs_due.size() == 0) begin
					report_mismatch("unexpected word, run_number", 64'd0, 64'(run_number));
				end else begin
					want = runs_due.pop_front();
					action_hits[want.action]++;
					if (action !== want.action)
						report_mismatch("action", 64'(want.action), 64'(action));
					if (run_number !== want.run_number)
						report_mismatch("run_number", 64'(want.run_number),
							64'(run_number));
					if (run_start !== want.run_start)
						report_mismatch("run_start", 64'(want.run_start), 64'(run_start));
					if (run_length !== want.run_length)
						report_mismatch("run_length", 64'(want.run_length),
							64'(run_length));
					if (run_frozen !== want.run_frozen)
						report_mismatch("run_frozen", 64'(want.run_frozen),
							64'(run_frozen));
					if (saturated !== want.saturated)
						report_mismatch("saturated", 64'(want.saturated), 64'(saturated));
				end
				// long hold-offs back the block up into its input
				if (runs_seen == 300 || runs_seen == 700)
					hold_left = 60;
				else if (runs_seen >= 450 && runs_seen < 550)
					hold_left = 0;
				else
					hold_left = $urandom_range(0, 4);
			end
			if (hold_left != 0) begin
				run_stall <= 1'b1;
				hold_left--;
			end else begin
				run_stall <= 1'b0;
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		int unsigned c, reps, incs, kind, i;
		// first word, then an incrementing run
		queue_tc(0, 0, 0, 0, 0, 1'b0);
		queue_tc(0, 0, 0, 1, 0, 1'b0);
		queue_tc(0, 0, 0, 2, 0, 1'b0);
		// back to the start of a longer run: new run
		queue_tc(0, 0, 0, 0, 0, 1'b0);
		// repeat on a run of one freezes it, then it stays frozen
		queue_tc(0, 0, 0, 0, 0, 1'b0);
		queue_tc(0, 0, 0, 0, 0, 1'b0);
		// frozen run reached at start plus length
		queue_tc(0, 0, 0, 3, 0, 1'b0);
		// carries across second, minute and hour
		queue_tc(0, 0, 0, 24, 0, 1'b0);
		queue_tc(0, 0, 1, 0, 0, 1'b0);
		queue_tc(0, 0, 0, 26, 0, 1'b0);
		queue_tc(0, 0, 59, 24, 0, 1'b0);
		queue_tc(0, 1, 0, 0, 0, 1'b0);
		queue_tc(0, 59, 59, 24, 0, 1'b0);
		queue_tc(1, 0, 0, 0, 0, 1'b0);
		queue_tc(23, 59, 59, 24, 0, 1'b0);
		// all fields at full width, then frozen there
		queue_tc(31, 63, 63, 31, 0, 1'b0);
		queue_tc(31, 63, 63, 31, 0, 1'b0);
		// repeat of the last word of an incrementing run: new run
		queue_tc(5, 5, 5, 5, 0, 1'b0);
		queue_tc(5, 5, 5, 6, 0, 1'b0);
		queue_tc(5, 5, 5, 6, 0, 1'b0);
		queue_tc(0, 63, 0, 0, 0, 1'b0);
		queue_tc(31, 0, 63, 0, 0, 1'b0);
		queue_tc(0, 0, 0, 31, 0, 1'b1);

		// random runs with noise and broken sequences
		while (timecodes_pending.size() < 1025) begin
			kind = $urandom_range(0, 9);
			if ($urandom_range(0, 1) == 0)
				c = $urandom_range(0, 86399) * SecFrames + $urandom_range(20, 24);
			else
				c = $urandom_range(0, 24 * HourFrames - 1);
			if (kind < 6) begin
				reps = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
				incs = $urandom_range(0, 10);
				queue_count(c, pick_gap(), 1'b0);
				for (i = 0; i < reps; i++)
					queue_count(c, pick_gap(), 1'b0);
				for (i = 1; i <= incs; i++)
					queue_count(c + reps + i, pick_gap(), 1'b0);
			end else if (kind < 8) begin
				queue_tc($urandom, $urandom, $urandom, $urandom, pick_gap(), 1'b0);
			end else if (kind == 8) begin
				queue_count(c, pick_gap(), 1'b0);
				queue_count(c + 1, pick_gap(), 1'b0);
				queue_count(c + 1, pick_gap(), 1'b0);
				queue_count(c, pick_gap(), 1'b0);
			end else begin
				queue_count(c, pick_gap(), 1'b1);
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (timecodes_pending.size() != 0 || tc_valid)
			@(posedge clk);
		while (runs_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d timecode words in: %0d new runs, %0d incrementing, %0d frozen extensions",
			words_taken, action_hits[ActNew], action_hits[ActInc], action_hits[ActFrozen]);
		$display("%0d run words checked, %0d mismatches", runs_seen, mismatches);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/tcri_pkg.sv
design/tcri_pos.sv
design/tcri_run.sv
design/timecode_run_index_builder_top.sv
tb/timecode_run_index_builder_top_test.sv
